// ===== rtl/core/ckca_pkg.sv =====
`default_nettype none

package ckca_pkg;

  // Quotient bits kept by the divider; one more than the result so that
  // a magnitude of 32768 is still told apart from an overflow.
  localparam int unsigned QuoW    = 17;
  localparam int unsigned DivCntW = $clog2(QuoW);
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [7:0]  RstRefRed    = 8'd132;
  localparam logic [7:0]  RstRefGreen  = 8'd119;
  localparam logic [7:0]  RstRefBlue   = 8'd48;
  localparam logic [9:0]  RstThreshold = 10'd30;
  localparam logic [10:0] RstWidth     = 11'd256;
  localparam logic [15:0] RstFov       = 16'd16384;

  typedef enum logic [2:0] {
    RegRefRed    = 3'd0,
    RegRefGreen  = 3'd1,
    RegRefBlue   = 3'd2,
    RegThreshold = 3'd3,
    RegWidth     = 3'd4,
    RegFov       = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  ref_red;
    logic [7:0]  ref_green;
    logic [7:0]  ref_blue;
    logic [9:0]  match_threshold;
    logic [10:0] image_width;
    logic [15:0] field_of_view;
  } cfg_t;

  typedef struct packed {
    logic accept;    // pixel taken this cycle
    logic snap;      // pixel carries frame end: hand totals to the math
    logic mul_cw;    // count * width
    logic mul_num;   // |2*sum - count*width| * fov, divisor
    logic div_init;  // overflow check, load divider
    logic div_step;  // one quotient bit
    logic load_out;  // write result register
  } cmd_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ckca_if.sv =====
`default_nettype none

interface ckca_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       frame_end;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, frame_end,
                  input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, frame_end,
                  output ready);
endinterface

interface ckca_res_if;
  logic               valid;
  logic               ready;
  logic               line_seen;
  logic signed [15:0] line_angle;

  modport source (output valid, line_seen, line_angle, input ready);
  modport sink   (input valid, line_seen, line_angle, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ckca_regs.sv =====
`default_nettype none

module ckca_regs
  import ckca_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_red         <= RstRefRed;
      cfg_q.ref_green       <= RstRefGreen;
      cfg_q.ref_blue        <= RstRefBlue;
      cfg_q.match_threshold <= RstThreshold;
      cfg_q.image_width     <= RstWidth;
      cfg_q.field_of_view   <= RstFov;
    end else if (wr_en) begin
      case (idx)
        RegRefRed:    cfg_q.ref_red         <= pwdata[7:0];
        RegRefGreen:  cfg_q.ref_green       <= pwdata[7:0];
        RegRefBlue:   cfg_q.ref_blue        <= pwdata[7:0];
        RegThreshold: cfg_q.match_threshold <= pwdata[9:0];
        RegWidth:     cfg_q.image_width     <= pwdata[10:0];
        RegFov:       cfg_q.field_of_view   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegRefRed:    prdata = DataW'(cfg_q.ref_red);
      RegRefGreen:  prdata = DataW'(cfg_q.ref_green);
      RegRefBlue:   prdata = DataW'(cfg_q.ref_blue);
      RegThreshold: prdata = DataW'(cfg_q.match_threshold);
      RegWidth:     prdata = DataW'(cfg_q.image_width);
      RegFov:       prdata = DataW'(cfg_q.field_of_view);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ckca_ctrl.sv =====
`default_nettype none

module ckca_ctrl
  import ckca_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_last_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMulCw  = 6'b000010,
    StMulNum = 6'b000100,
    StChk  = 6'b001000,
    StDiv  = 6'b010000,
    StFin  = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_vld_q, out_vld_d;

  // Pixels inside a frame flow while the math runs; only a frame end
  // waits for the math to be free.
  assign in_ready_o  = ~in_last_i | (state_q == StIdle);
  assign out_valid_o = out_vld_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = in_valid_i & in_ready_o;
    cmd_o.snap     = cmd_o.accept & in_last_i;
    state_d        = state_q;
    cnt_d          = cnt_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.snap) state_d = StMulCw;
      end
      StMulCw: begin
        cmd_o.mul_cw = 1'b1;
        state_d      = StMulNum;
      end
      StMulNum: begin
        cmd_o.mul_num = 1'b1;
        state_d       = StChk;
      end
      StChk: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = DivCntW'(QuoW - 1);
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = StFin;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StFin: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ckca_dp.sv =====
`default_nettype none

module ckca_dp
  import ckca_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire cmd_t       cmd_i,
  input  wire logic [7:0] pixel_red_i,
  input  wire logic [7:0] pixel_green_i,
  input  wire logic [7:0] pixel_blue_i,
  output logic            line_seen_o,
  output logic signed [15:0] line_angle_o
);

  localparam longint unsigned CountLimit = 64'(MAX_WIDTH) * 64'(MAX_HEIGHT);
  localparam longint unsigned SumLimit   = CountLimit * 64'(MAX_WIDTH - 1);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CntW = $clog2(CountLimit + 1);
  localparam int unsigned SumW = $clog2(SumLimit + 1);
  localparam int unsigned CwW  = CntW + WW;
  localparam int unsigned DifW = ((SumW + 1 > CwW) ? SumW + 1 : CwW) + 1;
  localparam int unsigned MagW = DifW - 1;
  localparam int unsigned NumW = MagW + 16;
  localparam int unsigned DenW = CwW + 1;
  localparam int unsigned RemW = (NumW > DenW + QuoW) ? NumW : DenW + QuoW;

  // ---------------- pixel side ----------------
  logic [WW-1:0]   w_eff;
  logic [ColW-1:0] col_q, col;
  logic [WW:0]     col_inc;
  logic [9:0]      diff;
  logic            match, take;
  logic [SumW:0]   sum_add;
  logic [SumW-1:0] sum_q, sum_new;
  logic [CntW-1:0] cnt_q, cnt_new;

  always_comb begin
    if (cfg_i.image_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_i.image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_i.image_width);
    end
  end

  // a column left beyond a narrowed width wraps to zero
  assign col = ((WW + 1)'(col_q) >= (WW + 1)'(w_eff)) ? '0 : col_q;
  assign col_inc = (WW + 1)'(col) + 1'b1;

  assign diff = 10'(abs_diff(pixel_red_i, cfg_i.ref_red))
              + 10'(abs_diff(pixel_green_i, cfg_i.ref_green))
              + 10'(abs_diff(pixel_blue_i, cfg_i.ref_blue));
  assign match = diff < cfg_i.match_threshold;

  assign sum_add = (SumW + 1)'(sum_q) + (SumW + 1)'(col);
  assign take    = match && (cnt_q != CntW'(CountLimit))
                   && (sum_add <= (SumW + 1)'(SumLimit));
  assign sum_new = take ? sum_add[SumW-1:0] : sum_q;
  assign cnt_new = take ? cnt_q + 1'b1 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.accept) begin
      if (cmd_i.snap) begin
        col_q <= '0;
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        col_q <= (col_inc >= (WW + 1)'(w_eff)) ? '0 : col_inc[ColW-1:0];
        sum_q <= sum_new;
        cnt_q <= cnt_new;
      end
    end
  end

  // ---------------- frame math ----------------
  logic [SumW-1:0] sum_s_q;
  logic [CntW-1:0] cnt_s_q;
  logic [CwW-1:0]  cw_q;
  logic [DifW-1:0] dif;
  logic [MagW-1:0] mag;
  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic            neg_q, seen_q, ovf_q;
  logic [RemW-1:0] rem_q, dsh_q;
  logic [QuoW-1:0] quo_q;
  logic signed [15:0] angle;

  assign dif = (DifW'(sum_s_q) << 1) - DifW'(cw_q);
  assign mag = dif[DifW-1] ? MagW'(-dif) : MagW'(dif);

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      sum_s_q <= sum_new;
      cnt_s_q <= cnt_new;
    end
    if (cmd_i.mul_cw) begin
      cw_q <= CwW'(cnt_s_q) * CwW'(w_eff);
    end
    if (cmd_i.mul_num) begin
      num_q  <= NumW'(mag) * NumW'(cfg_i.field_of_view);
      den_q  <= DenW'(cw_q) << 1;
      neg_q  <= dif[DifW-1];
      seen_q <= (cnt_s_q != '0);
    end
    if (cmd_i.div_init) begin
      ovf_q <= RemW'(num_q) >= (RemW'(den_q) << QuoW);
      rem_q <= RemW'(num_q);
      dsh_q <= RemW'(den_q) << (QuoW - 1);
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[QuoW-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QuoW-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  // sign applied to the truncated magnitude, then saturation
  always_comb begin
    if (!seen_q) begin
      angle = '0;
    end else if (neg_q) begin
      if (ovf_q || (quo_q > QuoW'(32768))) begin
        angle = 16'sh8000;
      end else begin
        angle = 16'(-quo_q);
      end
    end else begin
      if (ovf_q || (quo_q > QuoW'(32767))) begin
        angle = 16'sh7fff;
      end else begin
        angle = 16'(quo_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      line_seen_o  <= seen_q;
      line_angle_o <= angle;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/color_key_centroid_angle.sv =====
`default_nettype none

// Color-key column centroid: pixels in raster order come in on pix_i, one
// item per pixel with frame_end set on the last pixel of a frame. A pixel
// matches when the summed absolute RGB difference from the reference color
// is below match_threshold; matching columns are summed and counted.
// Each frame end gives one item on res_o: line_seen, and line_angle =
// (mean column / width - 0.5) * field_of_view, signed Q2.14, truncated
// toward zero and saturated, zero when nothing matched.
// Throughput: one pixel per cycle inside a frame. The per-frame math (two
// multiplies and a 17-step restoring divider) steps through StMulCw,
// StMulNum, StChk, StDiv and StFin after the frame-end pixel, then loads the
// output register; pixels of the next frame keep flowing meanwhile, only
// its frame-end pixel is held off (ready low) until the math unit is free.
// A stalled res_o holds the result in the output register; the math then
// waits in its final step, so a new frame end stalls behind it.
// Reset clears accumulators, controller and output valid, and loads the
// reference color, threshold, width and field of view with their defaults.
// Registers sit on the APB port at byte address 4*index.

module color_key_centroid_angle
  import ckca_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  ckca_pix_if.sink              pix_i,
  ckca_res_if.source            res_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  cmd_t cmd;

  ckca_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ckca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_last_i   (pix_i.frame_end),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd)
  );

  ckca_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .pixel_red_i   (pix_i.pixel_red),
    .pixel_green_i (pix_i.pixel_green),
    .pixel_blue_i  (pix_i.pixel_blue),
    .line_seen_o   (res_o.line_seen),
    .line_angle_o  (res_o.line_angle)
  );

endmodule

`default_nettype wire

// ===== tb/ckca_checker.sv =====
`timescale 1ns / 1ps

module ckca_checker
  import ckca_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  ckca_pix_if                   pix_i,
  ckca_res_if                   res_i,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  input  wire logic             pready,
  output int                    fail_count_o,
  output int                    pending_o
);

  // Accumulator ceilings for an overlong frame.
  localparam longint CountLimit = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
  localparam longint SumLimit   = CountLimit * longint'(MAX_WIDTH - 1);

  typedef struct packed {
    logic               seen;
    logic signed [15:0] angle;
  } line_res_t;

  cfg_t        cfg;
  int unsigned col_pos;
  longint      col_sum;
  longint      match_cnt;
  int          fails = 0;
  line_res_t   line_expect_q[$];

  function automatic int unsigned used_width(input logic [10:0] w);
    if (w == '0) return 1;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return w;
  endfunction

  function automatic int chan_dist(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // (2*sum - count*w) * fov / (2*count*w), truncated toward zero, saturated
  function automatic logic signed [15:0] centroid_angle(input longint s, input longint c,
                                                        input longint w, input longint fov);
    longint cw;
    longint q;
    cw = c * w;
    q  = ((2 * s - cw) * fov) / (2 * cw);
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    line_res_t   got;
    line_res_t   want;
    int unsigned w;
    int          diff;
    if (!rst_ni) begin
      cfg = '{ref_red: RstRefRed, ref_green: RstRefGreen, ref_blue: RstRefBlue,
              match_threshold: RstThreshold, image_width: RstWidth,
              field_of_view: RstFov};
      col_pos   = 0;
      col_sum   = 0;
      match_cnt = 0;
      line_expect_q.delete();
    end else begin
      // results first: an item accepted now never answers this edge's pixel
      if (res_i.valid && res_i.ready) begin
        got = '{seen: res_i.line_seen, angle: res_i.line_angle};
        if (line_expect_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected line result: seen=%0d angle=%0d", got.seen, got.angle);
        end else begin
          want = line_expect_q.pop_front();
          if (got.seen !== want.seen || got.angle !== want.angle) begin
            fails++;
            if (fails <= 10)
              $display("line result mismatch: expected seen=%0d angle=%0d, got seen=%0d angle=%0d",
                       want.seen, want.angle, got.seen, got.angle);
          end
        end
      end

      if (pix_i.valid && pix_i.ready) begin
        w = used_width(cfg.image_width);
        if (col_pos >= w) col_pos = 0;
        diff = chan_dist(pix_i.pixel_red, cfg.ref_red) +
               chan_dist(pix_i.pixel_green, cfg.ref_green) +
               chan_dist(pix_i.pixel_blue, cfg.ref_blue);
        if (diff < int'(cfg.match_threshold) && match_cnt < CountLimit &&
            col_sum + col_pos <= SumLimit) begin
          col_sum += col_pos;
          match_cnt++;
        end
        col_pos = (col_pos + 1 >= w) ? 0 : col_pos + 1;
        if (pix_i.frame_end) begin
          want.seen  = (match_cnt != 0);
          want.angle = want.seen ?
                       centroid_angle(col_sum, match_cnt, w, longint'(cfg.field_of_view)) : '0;
          line_expect_q.push_back(want);
          col_pos   = 0;
          col_sum   = 0;
          match_cnt = 0;
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[AddrW-1:2]))
          RegRefRed:    cfg.ref_red         = pwdata[7:0];
          RegRefGreen:  cfg.ref_green       = pwdata[7:0];
          RegRefBlue:   cfg.ref_blue        = pwdata[7:0];
          RegThreshold: cfg.match_threshold = pwdata[9:0];
          RegWidth:     cfg.image_width     = pwdata[10:0];
          RegFov:       cfg.field_of_view   = pwdata[15:0];
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= line_expect_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the color-key centroid block. Prediction and
// comparison live in ckca_checker, which watches both channels and the
// register port; this module only drives and decides.
module tb_top;
  import ckca_pkg::*;

  // No-accept stretches in a correct run come from the drain in quiesce, the
  // frame math, a drawn result stall and a drawn pixel gap, all far below IdleLimit.
  localparam int IdleLimit     = 2000;
  localparam int ItemsPerPhase = 50;

  logic             clk   = 1'b0;
  logic             rst_n = 1'b0;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic             pready;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  int               fail_count;
  int               pending;
  int               idle_cycles = 0;
  bit               src_idle_on;
  bit               snk_idle_on;

  // Current key color and how far near-key pixels stray from it.
  logic [7:0]       key_r;
  logic [7:0]       key_g;
  logic [7:0]       key_b;
  int               near_spread;

  ckca_pix_if pix_ch ();
  ckca_res_if res_ch ();

  color_key_centroid_angle dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .pix_i   (pix_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ckca_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .pix_i        (pix_ch),
    .res_i        (res_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The watchdog counts any pixel, result or register access as progress.
  always @(posedge clk) begin
    if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall before each item, none while snk_idle_on is off.
  // ready only drops when a stall is drawn, so it never toggles within a step.
  initial begin : result_sink
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = snk_idle_on ? $urandom_range(10, 0) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  // One pixel item. valid stays up across back-to-back items and only drops
  // when a gap is drawn.
  task automatic drive_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic last);
    int gap;
    gap = src_idle_on ? $urandom_range(10, 0) : 0;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel_red   <= r;
    pix_ch.pixel_green <= g;
    pix_ch.pixel_blue  <= b;
    pix_ch.frame_end   <= last;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // Setup + access phase. psel is left high so writes can go back to back;
  // the caller parks the bus after the last one.
  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic load_setup(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [9:0] thr, input logic [10:0] w,
                            input logic [15:0] fov);
    key_r       = r;
    key_g       = g;
    key_b       = b;
    near_spread = int'(thr) / 3 + 1;
    write_reg(RegRefRed, DataW'(r));
    write_reg(RegRefGreen, DataW'(g));
    write_reg(RegRefBlue, DataW'(b));
    write_reg(RegThreshold, DataW'(thr));
    write_reg(RegWidth, DataW'(w));
    write_reg(RegFov, DataW'(fov));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop sending, drain expected results, then cover the frame math latency
  // so the block is truly idle.
  task automatic quiesce();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Channel value near the key, so summed differences land around threshold.
  function automatic logic [7:0] near_channel(input logic [7:0] base);
    int v;
    v = int'(base) + int'($urandom_range(2 * near_spread, 0)) - near_spread;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return 8'(v);
  endfunction

  initial begin : stimulus
    int frame_len;
    int phase_items;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    pix_ch.valid       <= 1'b0;
    pix_ch.pixel_red   <= '0;
    pix_ch.pixel_green <= '0;
    pix_ch.pixel_blue  <= '0;
    pix_ch.frame_end   <= 1'b0;
    src_idle_on        <= 1'b1;
    snk_idle_on        <= 1'b1;
    key_r       = RstRefRed;
    key_g       = RstRefGreen;
    key_b       = RstRefBlue;
    near_spread = int'(RstThreshold) / 3 + 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed, reset settings (key 132/119/48, threshold 30, width 256) ---
    // Channel extremes, exact key, summed difference one below and at the
    // threshold; the frame-end pixel itself matches and is counted.
    drive_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    drive_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    drive_pixel(8'd132, 8'd119, 8'd48, 1'b0);
    drive_pixel(8'd161, 8'd119, 8'd48, 1'b0);
    drive_pixel(8'd162, 8'd119, 8'd48, 1'b0);
    drive_pixel(8'd132, 8'd119, 8'd48, 1'b1);
    // one-pixel frame with no match: line unseen, angle zero
    drive_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    // width shrunk mid-frame: counter sits at column 4, wraps to 0 at width 2
    for (int i = 0; i < 4; i++) drive_pixel(8'd132, 8'd119, 8'd48, 1'b0);
    quiesce();
    write_reg(RegWidth, DataW'(2));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    drive_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    drive_pixel(8'd132, 8'd119, 8'd48, 1'b0);
    drive_pixel(8'd132, 8'd119, 8'd48, 1'b1);

    // --- random frames across register settings, extremes first ---
    for (int p = 0; p < 6; p++) begin
      quiesce();
      src_idle_on <= (p != 4);
      snk_idle_on <= (p != 4);
      case (p)
        // threshold zero: nothing can match; width zero acts as one
        0: load_setup(8'd0, 8'd0, 8'd0, 10'd0, 11'd0, 16'hFFFF);
        // everything matches at column 0: most negative angle
        1: load_setup(8'hFF, 8'hFF, 8'hFF, 10'h3FF, 11'd1, 16'hFFFF);
        // width above the maximum is clamped; zero field of view
        2: load_setup(8'($urandom), 8'($urandom), 8'($urandom), 10'd766, 11'h7FF, 16'd0);
        3: load_setup(8'($urandom), 8'($urandom), 8'($urandom),
                      10'($urandom_range(200, 20)), 11'($urandom_range(16, 2)),
                      16'($urandom));
        // no idling on either side here
        4: load_setup(8'($urandom), 8'($urandom), 8'($urandom),
                      10'($urandom_range(400, 10)), 11'($urandom_range(40, 1)),
                      16'($urandom));
        default: begin
          // one-row frame, single match in the last column: large
          // positive angle; misses are kept far from the black key
          load_setup(8'd0, 8'd0, 8'd0, 10'd60, 11'd64, 16'hFFFF);
          for (int i = 0; i < 63; i++)
            drive_pixel(8'($urandom) | 8'h80, 8'($urandom), 8'($urandom), 1'b0);
          drive_pixel(8'd10, 8'd10, 8'd10, 1'b1);
        end
      endcase

      // Mostly short frames, now and then a longer one; half the pixels
      // sit near the key so matches and near-misses both show up.
      phase_items = 0;
      while (phase_items < ItemsPerPhase) begin
        frame_len = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 13) :
                                                 $urandom_range(12, 1);
        for (int i = 0; i < frame_len; i++) begin
          if ($urandom_range(1, 0) == 1)
            drive_pixel(near_channel(key_r), near_channel(key_g), near_channel(key_b),
                        i == frame_len - 1);
          else
            drive_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == frame_len - 1);
        end
        phase_items += frame_len;
      end
    end

    quiesce();
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ckca_pkg.sv
rtl/core/ckca_if.sv
rtl/core/ckca_regs.sv
rtl/core/ckca_ctrl.sv
rtl/core/ckca_dp.sv
rtl/core/color_key_centroid_angle.sv
tb/ckca_checker.sv
tb/tb_top.sv
